// ===== sv/bas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocking analysis statistics package
// Types, constants and saturating Q32.32 helpers for the blocking analysis block.
// ----------------------------------------------------------------------------
package bas_pkg;

	localparam int MAX_LEVELS_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int RES_CAP = 16;
	localparam int BLK_W = 32;
	localparam int Q_W = 64;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_COUNT,
		OP_SEED,
		OP_LOAD,
		OP_CORR_MUL,
		OP_CORR_ACC,
		OP_CMS_DIV,
		OP_CMS_ACC,
		OP_CMF_DIV,
		OP_CMF_ACC,
		OP_MEAN_DIV,
		OP_MEAN_ACC,
		OP_M2_MUL,
		OP_M2_ACC,
		OP_WB,
		OP_EMIT_SAT,
		OP_NEXT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SAT_OUT,
		ST_SEED,
		ST_LOAD,
		ST_BRANCH,
		ST_CORR_WAIT,
		ST_CMS_DIV,
		ST_CMS_WAIT,
		ST_CMF_DIV,
		ST_CMF_WAIT,
		ST_MEAN_DIV,
		ST_MEAN_WAIT,
		ST_M2_MUL,
		ST_M2_WAIT,
		ST_WB,
		ST_NEXT
	} ctl_state_t;

	typedef struct packed {
		logic   ld_in;
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic full;
		logic seed;
		logic close;
		logic cnt_gt1;
		logic idx_last;
		logic emit_ok;
		logic out_free;
		logic mul_done;
		logic div_done;
	} sts_t;

	function automatic logic signed [Q_W-1:0] sadd(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1]) begin
			return s[Q_W] ? Q_MIN : Q_MAX;
		end
		return s[Q_W-1:0];
	endfunction

	function automatic logic signed [Q_W-1:0] ssub(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} - {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1]) begin
			return s[Q_W] ? Q_MIN : Q_MAX;
		end
		return s[Q_W-1:0];
	endfunction

	function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] x);
		return x[Q_W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [Q_W-1:0] from_mag(input logic [Q_W-1:0] m,
			input logic neg);
		if (!neg) begin
			return m[Q_W-1] ? Q_MAX : m;
		end
		return m[Q_W-1] ? Q_MIN : (~m + 1'b1);
	endfunction

	function automatic logic signed [Q_W-1:0] half_sum(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		logic signed [Q_W:0] f;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		f = s >>> 1;
		if (s[Q_W] && s[0]) begin
			f = f + 1'b1;
		end
		return f[Q_W-1:0];
	endfunction

endpackage

// ===== sv/bas_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying an opcode and a Q16.16 sample.
// ----------------------------------------------------------------------------
interface bas_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink (input valid, input opcode, input sample, output ready);
endinterface

// ===== sv/bas_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one blocking level result.
// ----------------------------------------------------------------------------
interface bas_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         level;
	logic [4:0]         levels_in_use;
	logic [31:0]        block_count;
	logic signed [63:0] block_average;
	logic signed [63:0] running_mean;
	logic [62:0]        sum_sq_dev;
	logic signed [63:0] lag_covariance_sum;
	logic               saturated;
	logic               last;

	modport source (output valid, output level, output levels_in_use, output block_count,
		output block_average, output running_mean, output sum_sq_dev,
		output lag_covariance_sum, output saturated, output last, input ready);
	modport sink (input valid, input level, input levels_in_use, input block_count,
		input block_average, input running_mean, input sum_sq_dev,
		input lag_covariance_sum, input saturated, input last, output ready);
endinterface

// ===== sv/bas_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q32.32 multiplier
// Sequential saturating signed multiply from four 32x32 partial products.
// ----------------------------------------------------------------------------
module bas_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [bas_pkg::Q_W-1:0]  a,
	input  logic signed [bas_pkg::Q_W-1:0]  b,
	output logic                            done,
	output logic signed [bas_pkg::Q_W-1:0]  res
);
	import bas_pkg::*;

	logic [63:0]  xm_q;
	logic [63:0]  ym_q;
	logic         neg_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  xs;
	logic [31:0]  ys;
	logic [63:0]  pp_c;
	logic [127:0] add_c;

	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				xs = xm_q[31:0];
				ys = ym_q[31:0];
			end
			2'd1: begin
				xs = xm_q[31:0];
				ys = ym_q[63:32];
			end
			2'd2: begin
				xs = xm_q[63:32];
				ys = ym_q[31:0];
			end
			default: begin
				xs = xm_q[63:32];
				ys = ym_q[63:32];
			end
		endcase
		pp_c = xs * ys;
		case (step_q)
			3'd1: add_c = {64'h0, pp_q};
			3'd2: add_c = {32'h0, pp_q, 32'h0};
			3'd3: add_c = {32'h0, pp_q, 32'h0};
			3'd4: add_c = {pp_q, 64'h0};
			default: add_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xm_q  <= mag(a);
			ym_q  <= mag(b);
			neg_q <= a[Q_W-1] ^ b[Q_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q  <= pp_c;
			acc_q <= acc_q + add_c;
		end
	end

	assign done = done_q;
	assign res = (|acc_q[127:96]) ? (neg_q ? Q_MIN : Q_MAX) : from_mag(acc_q[95:32], neg_q);

endmodule

// ===== sv/bas_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q32.32 divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module bas_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [bas_pkg::Q_W-1:0]    d,
	input  logic [bas_pkg::BLK_W-1:0]         n,
	output logic                              done,
	output logic signed [bas_pkg::Q_W-1:0]    res
);
	import bas_pkg::*;

	logic [Q_W-1:0]   qd_q;
	logic [BLK_W-1:0] rem_q;
	logic [BLK_W-1:0] n_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BLK_W+1:0] trial;

	assign trial = {1'b0, rem_q, qd_q[Q_W-1]} - {2'b00, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= mag(d);
			rem_q <= '0;
			n_q   <= n;
			neg_q <= d[Q_W-1];
		end else if (busy_q) begin
			if (!trial[BLK_W+1]) begin
				rem_q <= trial[BLK_W-1:0];
				qd_q  <= {qd_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[BLK_W-2:0], qd_q[Q_W-1]};
				qd_q  <= {qd_q[Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res = from_mag(qd_q, neg_q);

endmodule

// ===== sv/bas_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocking analysis datapath
// Per-level state, working registers, arithmetic units and result register.
// ----------------------------------------------------------------------------
module bas_dp #(
	parameter int MAX_LEVELS = bas_pkg::MAX_LEVELS_DEF,
	parameter int COUNT_BITS = bas_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bas_pkg::cmd_t       cmd,
	output bas_pkg::sts_t       sts,
	input  logic                in_opcode,
	input  logic signed [31:0]  in_sample,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [3:0]          out_level,
	output logic [4:0]          out_levels_in_use,
	output logic [31:0]         out_block_count,
	output logic signed [63:0]  out_block_average,
	output logic signed [63:0]  out_running_mean,
	output logic [62:0]         out_sum_sq_dev,
	output logic signed [63:0]  out_lag_covariance_sum,
	output logic                out_saturated,
	output logic                out_last
);
	import bas_pkg::*;

	localparam int LW = $clog2(MAX_LEVELS);
	localparam int OW = $clog2(MAX_LEVELS + 1);
	localparam int NW = $clog2(RES_CAP + 1);

	logic                   op_q;
	logic signed [Q_W-1:0]  x_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [OW-1:0]          open_q;
	logic                   seed_q;
	logic [LW-1:0]          idx_q;
	logic [NW-1:0]          nres_q;

	logic signed [Q_W-1:0]  pa_q   [MAX_LEVELS];
	logic [BLK_W-1:0]       bd_q   [MAX_LEVELS];
	logic signed [Q_W-1:0]  mean_q [MAX_LEVELS];
	logic signed [Q_W-1:0]  m2a_q  [MAX_LEVELS];
	logic signed [Q_W-1:0]  cmfa_q [MAX_LEVELS];
	logic signed [Q_W-1:0]  cmsa_q [MAX_LEVELS];
	logic signed [Q_W-1:0]  csa_q  [MAX_LEVELS];
	logic signed [Q_W-1:0]  prva_q [MAX_LEVELS];

	logic signed [Q_W-1:0]  b_q;
	logic [BLK_W-1:0]       cnt_q;
	logic signed [Q_W-1:0]  prev_q;
	logic signed [Q_W-1:0]  cmf_q;
	logic signed [Q_W-1:0]  cms_q;
	logic signed [Q_W-1:0]  mn_q;
	logic signed [Q_W-1:0]  m2_q;
	logic signed [Q_W-1:0]  cs_q;
	logic signed [Q_W-1:0]  d2_q;

	logic                   out_valid_q;
	logic [3:0]             o_level_q;
	logic [4:0]             o_levels_q;
	logic [31:0]            o_count_q;
	logic signed [63:0]     o_avg_q;
	logic signed [63:0]     o_mean_q;
	logic [62:0]            o_m2_q;
	logic signed [63:0]     o_cs_q;
	logic                   o_sat_q;
	logic                   o_last_q;

	logic signed [Q_W-1:0]  b_new;
	logic [BLK_W-1:0]       bd_rd;
	logic [BLK_W-1:0]       cnt_new;
	logic                   close;
	logic [OW-1:0]          idx_nxt;
	logic                   next_close;
	logic [COUNT_BITS-1:0]  count_inc;
	logic [LW-1:0]          top_idx;
	logic                   seed_new;
	logic                   mul_start;
	logic signed [Q_W-1:0]  mul_a;
	logic signed [Q_W-1:0]  mul_b;
	logic                   mul_done;
	logic signed [Q_W-1:0]  mul_res;
	logic                   div_start;
	logic signed [Q_W-1:0]  div_d;
	logic [BLK_W-1:0]       div_n;
	logic                   div_done;
	logic signed [Q_W-1:0]  div_res;
	logic signed [Q_W-1:0]  m2_sum;
	logic                   emit_ok;

	function automatic logic [COUNT_BITS-1:0] low_mask(input logic [OW-1:0] k);
		logic [COUNT_BITS-1:0] m;
		for (int i = 0; i < COUNT_BITS; i++) begin
			m[i] = (i < int'(k));
		end
		return m;
	endfunction

	assign bd_rd      = bd_q[idx_q];
	assign cnt_new    = (&bd_rd) ? bd_rd : bd_rd + 1'b1;
	assign b_new      = sadd(pa_q[idx_q], x_q >>> idx_q);
	assign close      = (count_q & low_mask(OW'(idx_q))) == '0;
	assign idx_nxt    = OW'(idx_q) + OW'(1);
	assign next_close = (idx_nxt < open_q) && ((count_q & low_mask(idx_nxt)) == '0);
	assign count_inc  = count_q + 1'b1;
	assign top_idx    = LW'(open_q - OW'(1));
	assign seed_new   = (open_q != '0) && (open_q < OW'(MAX_LEVELS)) &&
		((count_inc & low_mask(open_q - OW'(1))) == '0);
	assign m2_sum     = sadd(m2_q, mul_res);
	assign emit_ok    = nres_q < NW'(RES_CAP);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = d2_q;
		mul_b     = ssub(b_q, mn_q);
		div_start = 1'b0;
		div_d     = ssub(b_q, mn_q);
		div_n     = cnt_q;
		case (cmd.op)
			OP_CORR_MUL: begin
				mul_start = 1'b1;
				mul_a     = ssub(prev_q, cmf_q);
				mul_b     = ssub(b_q, cms_q);
			end
			OP_M2_MUL: mul_start = 1'b1;
			OP_CMS_DIV: begin
				div_start = 1'b1;
				div_d     = ssub(b_q, cms_q);
				div_n     = cnt_q - 1'b1;
			end
			OP_CMF_DIV: begin
				div_start = 1'b1;
				div_d     = ssub(b_q, cmf_q);
			end
			OP_MEAN_DIV: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	bas_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	bas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.d      (div_d),
		.n      (div_n),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			open_q  <= '0;
			seed_q  <= 1'b0;
			idx_q   <= '0;
			nres_q  <= '0;
			op_q    <= 1'b0;
			for (int k = 0; k < MAX_LEVELS; k++) begin
				pa_q[k]   <= '0;
				bd_q[k]   <= '0;
				mean_q[k] <= '0;
				m2a_q[k]  <= '0;
				cmfa_q[k] <= '0;
				cmsa_q[k] <= '0;
				csa_q[k]  <= '0;
				prva_q[k] <= '0;
			end
		end else begin
			if (cmd.ld_in) begin
				op_q <= in_opcode;
			end
			case (cmd.op)
				OP_CLEAR: begin
					count_q <= '0;
					open_q  <= '0;
					for (int k = 0; k < MAX_LEVELS; k++) begin
						pa_q[k]   <= '0;
						bd_q[k]   <= '0;
						mean_q[k] <= '0;
						m2a_q[k]  <= '0;
						cmfa_q[k] <= '0;
						cmsa_q[k] <= '0;
						csa_q[k]  <= '0;
						prva_q[k] <= '0;
					end
				end
				OP_COUNT: begin
					count_q <= count_inc;
					seed_q  <= seed_new;
					idx_q   <= '0;
					nres_q  <= '0;
					if (open_q == '0) begin
						open_q <= OW'(1);
					end
				end
				OP_SEED: begin
					pa_q[LW'(open_q)] <= half_sum(mean_q[top_idx], pa_q[top_idx]);
					open_q <= open_q + OW'(1);
				end
				OP_LOAD: begin
					if (!close) begin
						pa_q[idx_q] <= b_new;
					end
				end
				OP_WB: begin
					pa_q[idx_q]   <= '0;
					bd_q[idx_q]   <= cnt_q;
					mean_q[idx_q] <= mn_q;
					m2a_q[idx_q]  <= m2_q;
					cmfa_q[idx_q] <= cmf_q;
					cmsa_q[idx_q] <= cms_q;
					csa_q[idx_q]  <= cs_q;
					prva_q[idx_q] <= b_q;
					if (emit_ok) begin
						nres_q <= nres_q + NW'(1);
					end
				end
				OP_NEXT: idx_q <= idx_q + LW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			x_q <= {{16{in_sample[31]}}, in_sample, 16'h0000};
		end
		case (cmd.op)
			OP_LOAD: begin
				b_q    <= b_new;
				cnt_q  <= cnt_new;
				prev_q <= prva_q[idx_q];
				cmf_q  <= cmfa_q[idx_q];
				cms_q  <= cmsa_q[idx_q];
				mn_q   <= mean_q[idx_q];
				m2_q   <= m2a_q[idx_q];
				cs_q   <= csa_q[idx_q];
			end
			OP_CORR_ACC: cs_q <= sadd(cs_q, mul_res);
			OP_CMS_ACC:  cms_q <= sadd(cms_q, div_res);
			OP_CMF_ACC:  cmf_q <= sadd(cmf_q, div_res);
			OP_MEAN_DIV: d2_q <= ssub(b_q, mn_q);
			OP_MEAN_ACC: mn_q <= sadd(mn_q, div_res);
			OP_M2_ACC:   m2_q <= m2_sum[Q_W-1] ? '0 : m2_sum;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == OP_WB && emit_ok) || cmd.op == OP_EMIT_SAT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WB && emit_ok) begin
			o_level_q  <= 4'(idx_q);
			o_levels_q <= 5'(open_q);
			o_count_q  <= cnt_q;
			o_avg_q    <= b_q;
			o_mean_q   <= mn_q;
			o_m2_q     <= m2_q[62:0];
			o_cs_q     <= cs_q;
			o_sat_q    <= 1'b0;
			o_last_q   <= (nres_q == NW'(RES_CAP - 1)) || !next_close;
		end else if (cmd.op == OP_EMIT_SAT) begin
			o_level_q  <= '0;
			o_levels_q <= 5'(open_q);
			o_count_q  <= '0;
			o_avg_q    <= '0;
			o_mean_q   <= '0;
			o_m2_q     <= '0;
			o_cs_q     <= '0;
			o_sat_q    <= 1'b1;
			o_last_q   <= 1'b1;
		end
	end

	assign out_valid              = out_valid_q;
	assign out_level              = o_level_q;
	assign out_levels_in_use      = o_levels_q;
	assign out_block_count        = o_count_q;
	assign out_block_average      = o_avg_q;
	assign out_running_mean       = o_mean_q;
	assign out_sum_sq_dev         = o_m2_q;
	assign out_lag_covariance_sum = o_cs_q;
	assign out_saturated          = o_sat_q;
	assign out_last               = o_last_q;

	assign sts.is_clear = op_q;
	assign sts.full     = &count_q;
	assign sts.seed     = seed_q;
	assign sts.close    = close;
	assign sts.cnt_gt1  = cnt_q > BLK_W'(1);
	assign sts.idx_last = idx_nxt == open_q;
	assign sts.emit_ok  = emit_ok;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

endmodule

// ===== sv/bas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocking analysis controller
// Sequences the per-level update steps and the result transfers.
// ----------------------------------------------------------------------------
module bas_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bas_pkg::sts_t sts,
	output bas_pkg::cmd_t cmd
);
	import bas_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.ld_in = 1'b0;
		cmd.op    = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.is_clear) begin
					cmd.op  = OP_CLEAR;
					state_d = ST_IDLE;
				end else if (sts.full) begin
					state_d = ST_SAT_OUT;
				end else begin
					cmd.op  = OP_COUNT;
					state_d = ST_SEED;
				end
			end
			ST_SAT_OUT: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT_SAT;
					state_d = ST_IDLE;
				end
			end
			ST_SEED: begin
				if (sts.seed) begin
					cmd.op = OP_SEED;
				end
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = sts.close ? ST_BRANCH : ST_NEXT;
			end
			ST_BRANCH: begin
				if (sts.cnt_gt1) begin
					cmd.op  = OP_CORR_MUL;
					state_d = ST_CORR_WAIT;
				end else begin
					cmd.op  = OP_CMF_DIV;
					state_d = ST_CMF_WAIT;
				end
			end
			ST_CORR_WAIT: begin
				if (sts.mul_done) begin
					cmd.op  = OP_CORR_ACC;
					state_d = ST_CMS_DIV;
				end
			end
			ST_CMS_DIV: begin
				cmd.op  = OP_CMS_DIV;
				state_d = ST_CMS_WAIT;
			end
			ST_CMS_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = OP_CMS_ACC;
					state_d = ST_CMF_DIV;
				end
			end
			ST_CMF_DIV: begin
				cmd.op  = OP_CMF_DIV;
				state_d = ST_CMF_WAIT;
			end
			ST_CMF_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = OP_CMF_ACC;
					state_d = ST_MEAN_DIV;
				end
			end
			ST_MEAN_DIV: begin
				cmd.op  = OP_MEAN_DIV;
				state_d = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = OP_MEAN_ACC;
					state_d = ST_M2_MUL;
				end
			end
			ST_M2_MUL: begin
				cmd.op  = OP_M2_MUL;
				state_d = ST_M2_WAIT;
			end
			ST_M2_WAIT: begin
				if (sts.mul_done) begin
					cmd.op  = OP_M2_ACC;
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (!sts.emit_ok || sts.out_free) begin
					cmd.op  = OP_WB;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sts.idx_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.op  = OP_NEXT;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/blocking_analysis_stats_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocking analysis statistics
// Streaming blocking analysis over Q16.16 samples with per-level statistics.
// ----------------------------------------------------------------------------
// Usage: the req channel takes one transfer per command, either a sample
// (opcode 0) or a clear (opcode 1). The rsp channel returns one transfer per
// blocking level whose block closes on a sample, in ascending level order,
// with last set on the final one. A clear produces no result; a sample that
// arrives once the sample count is full produces a single saturated result.
// The block handles one command at a time. For each closing level, a sample
// runs serial divisions and multiplications on the shared units: three
// divisions and two multiplications when the level holds more than one block,
// else two divisions and one multiplication. Open levels that do not close
// only add the sample to their partial block sum.
// Reset clears every level, the counters and the result valid flag at once.
// When the receiver stalls, the result register holds its transfer and the
// block waits before writing the next result; a new command may be accepted
// while the last result of the previous one is still pending.
// ----------------------------------------------------------------------------
module blocking_analysis_stats_top #(
	parameter int MAX_LEVELS = bas_pkg::MAX_LEVELS_DEF,
	parameter int COUNT_BITS = bas_pkg::COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bas_in_if.sink     req,
	bas_out_if.source  rsp
);
	import bas_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bas_dp #(
		.MAX_LEVELS (MAX_LEVELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.in_opcode              (req.opcode),
		.in_sample              (req.sample),
		.out_ready              (rsp.ready),
		.out_valid              (rsp.valid),
		.out_level              (rsp.level),
		.out_levels_in_use      (rsp.levels_in_use),
		.out_block_count        (rsp.block_count),
		.out_block_average      (rsp.block_average),
		.out_running_mean       (rsp.running_mean),
		.out_sum_sq_dev         (rsp.sum_sq_dev),
		.out_lag_covariance_sum (rsp.lag_covariance_sum),
		.out_saturated          (rsp.saturated),
		.out_last               (rsp.last)
	);

endmodule

// ===== sim/tb_blocking_analysis_stats_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocking analysis statistics testbench
// Drives samples and clears into the block with bursty traffic and a stalling
// receiver, predicts every per-level result in fixed point and checks each
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_blocking_analysis_stats_top;

	localparam int NLEV = bas_pkg::MAX_LEVELS_DEF;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_CLEAR = 1'b1;
	localparam longint signed QHI = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint signed QLO = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [3:0]         level;
		logic [4:0]         levels_in_use;
		logic [31:0]        block_count;
		logic signed [63:0] block_average;
		logic signed [63:0] running_mean;
		logic [62:0]        sum_sq_dev;
		logic signed [63:0] lag_covariance_sum;
		logic               saturated;
		logic               last;
	} level_result_t;

	logic clk;
	logic arst_n;

	bas_in_if  req ();
	bas_out_if rsp ();

	blocking_analysis_stats_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	level_result_t exp_results[$];

	longint unsigned samples_seen;
	int unsigned     depth_open;
	longint signed   acc_partial[NLEV];
	longint unsigned acc_blocks[NLEV];
	longint signed   stat_mean[NLEV];
	longint signed   stat_m2[NLEV];
	longint signed   corr_first[NLEV];
	longint signed   corr_second[NLEV];
	longint signed   corr_acc[NLEV];
	longint signed   prev_avg[NLEV];

	int errors;
	int mismatches;
	int n_items;
	int n_clears;
	int n_results;
	int idle_cycles;
	int max_depth;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint signed q_add(longint signed a, longint signed b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? QLO : QHI;
		return s[63:0];
	endfunction

	function automatic longint signed q_sub(longint signed a, longint signed b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? QLO : QHI;
		return s[63:0];
	endfunction

	function automatic longint unsigned q_abs(longint signed x);
		return x < 0 ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	function automatic longint signed q_signed(longint unsigned m, logic neg);
		if (!neg) return m[63] ? QHI : longint'(m);
		if (m[63]) return QLO;
		return -longint'(m);
	endfunction

	function automatic longint signed q_mul(longint signed a, longint signed b);
		logic [127:0] p;
		logic neg;
		neg = (a < 0) != (b < 0);
		p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
		if (p[127:96] != 0) return neg ? QLO : QHI;
		return q_signed(p[95:32], neg);
	endfunction

	function automatic longint signed q_div(longint signed d, longint unsigned n);
		return q_signed(q_abs(d) / n, d < 0);
	endfunction

	function automatic longint signed q_mid(longint signed a, longint signed b);
		logic signed [64:0] s;
		logic signed [64:0] f;
		s = {a[63], a} + {b[63], b};
		f = s >>> 1;
		if (s[64] && s[0]) f = f + 1;
		return f[63:0];
	endfunction

	task automatic clear_levels();
		samples_seen = 0;
		depth_open = 0;
		for (int k = 0; k < NLEV; k++) begin
			acc_partial[k] = 0;
			acc_blocks[k] = 0;
			stat_mean[k] = 0;
			stat_m2[k] = 0;
			corr_first[k] = 0;
			corr_second[k] = 0;
			corr_acc[k] = 0;
			prev_avg[k] = 0;
		end
	endtask

	task automatic predict_sample(logic signed [31:0] smp);
		longint signed x;
		longint signed b;
		longint signed d;
		longint unsigned cnt;
		level_result_t r;
		int n;
		int first;
		n = 0;
		first = exp_results.size();
		if (samples_seen >= 64'hFFFF_FFFF) begin
			r = '0;
			r.levels_in_use = depth_open[4:0];
			r.saturated = 1'b1;
			r.last = 1'b1;
			exp_results = {exp_results, r};
			return;
		end
		x = longint'(smp) <<< 16;
		samples_seen++;
		if (depth_open == 0) begin
			depth_open = 1;
		end else if (depth_open < NLEV &&
				(samples_seen & ((64'd1 << (depth_open - 1)) - 1)) == 0) begin
			acc_partial[depth_open] = q_mid(stat_mean[depth_open-1],
				acc_partial[depth_open-1]);
			depth_open++;
		end
		if (depth_open > max_depth) max_depth = depth_open;
		for (int k = 0; k < depth_open; k++) begin
			acc_partial[k] = q_add(acc_partial[k], x >>> k);
			if ((samples_seen & ((64'd1 << k) - 1)) == 0) begin
				b = acc_partial[k];
				if (acc_blocks[k] < 64'hFFFF_FFFF) acc_blocks[k]++;
				cnt = acc_blocks[k];
				if (cnt > 1) begin
					corr_acc[k] = q_add(corr_acc[k], q_mul(q_sub(prev_avg[k], corr_first[k]),
						q_sub(b, corr_second[k])));
					d = q_sub(b, corr_second[k]);
					corr_second[k] = q_add(corr_second[k], q_div(d, cnt - 1));
				end
				d = q_sub(b, corr_first[k]);
				corr_first[k] = q_add(corr_first[k], q_div(d, cnt));
				d = q_sub(b, stat_mean[k]);
				stat_mean[k] = q_add(stat_mean[k], q_div(d, cnt));
				stat_m2[k] = q_add(stat_m2[k], q_mul(d, q_sub(b, stat_mean[k])));
				if (stat_m2[k] < 0) stat_m2[k] = 0;
				prev_avg[k] = b;
				acc_partial[k] = 0;
				if (n < bas_pkg::RES_CAP) begin
					r.level = k[3:0];
					r.levels_in_use = depth_open[4:0];
					r.block_count = cnt[31:0];
					r.block_average = b;
					r.running_mean = stat_mean[k];
					r.sum_sq_dev = stat_m2[k][62:0];
					r.lag_covariance_sum = corr_acc[k];
					r.saturated = 1'b0;
					r.last = 1'b0;
					exp_results = {exp_results, r};
					n++;
				end
			end
		end
		if (n > 0) exp_results[first + n - 1].last = 1'b1;
	endtask

	// Called at a falling edge; returns at a falling edge once the transfer and the requested gap are done.
	task automatic send_item(logic op, logic signed [31:0] smp, int gap);
		req.valid = 1'b1;
		req.opcode = op;
		req.sample = smp;
		do @(posedge clk); while (!req.ready);
		n_items++;
		if (op == OPC_CLEAR) begin
			n_clears++;
			clear_levels();
		end else begin
			predict_sample(smp);
		end
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $signed($urandom_range(0, 2047)) - 1024;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap(ref int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 12);
		return $urandom_range(1, 400);
	endfunction

	task automatic test_extremes();
		send_item(OPC_SAMPLE, 32'sh7FFF_FFFF, 0);
		send_item(OPC_SAMPLE, 32'sh7FFF_FFFF, 3);
		send_item(OPC_SAMPLE, 32'sh8000_0000, 0);
		send_item(OPC_SAMPLE, 32'sh8000_0000, 0);
		send_item(OPC_SAMPLE, 32'sh0000_0000, 1);
		send_item(OPC_SAMPLE, -32'sd1, 0);
		send_item(OPC_SAMPLE, 32'sd1, 0);
		send_item(OPC_SAMPLE, 32'sh7FFF_FFFF, 0);
		for (int i = 0; i < 8; i++)
			send_item(OPC_SAMPLE, (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, i % 3);
	endtask

	task automatic test_clear();
		send_item(OPC_CLEAR, 32'sh0, 2);
		send_item(OPC_CLEAR, -32'sd1, 0);
		send_item(OPC_SAMPLE, 32'sh0001_0000, 0);
		send_item(OPC_SAMPLE, -32'sh0001_0000, 0);
		send_item(OPC_SAMPLE, 32'sh0000_8000, 0);
		send_item(OPC_CLEAR, 32'sh5A5A_A5A5, 0);
		send_item(OPC_SAMPLE, 32'sh0002_0000, 5);
	endtask

	task automatic test_random(int count);
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 2)
				send_item(OPC_CLEAR, $urandom, pick_gap(burst_left));
			else
				send_item(OPC_SAMPLE, pick_sample(), pick_gap(burst_left));
		end
	endtask

	// Receiver stall pattern: phases of steady readiness, random stalls and long holds.
	initial begin
		int mode;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(50, 600)) begin
				@(negedge clk);
				case (mode)
					0: rsp.ready = 1'b1;
					1: rsp.ready = 1'($urandom_range(0, 1));
					default: rsp.ready = ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		level_result_t got;
		level_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.level = rsp.level;
			got.levels_in_use = rsp.levels_in_use;
			got.block_count = rsp.block_count;
			got.block_average = rsp.block_average;
			got.running_mean = rsp.running_mean;
			got.sum_sq_dev = rsp.sum_sq_dev;
			got.lag_covariance_sum = rsp.lag_covariance_sum;
			got.saturated = rsp.saturated;
			got.last = rsp.last;
			n_results++;
			if (exp_results.size() == 0) begin
				errors++;
				$display("unexpected result transfer: level %0d", got.level);
			end else begin
				want = exp_results.pop_front();
				if (got !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp lvl %0d use %0d cnt %0d avg %h mean %h",
							want.level, want.levels_in_use, want.block_count,
							want.block_average, want.running_mean);
						$display("          exp m2 %h cov %h sat %b last %b",
							want.sum_sq_dev, want.lag_covariance_sum, want.saturated, want.last);
						$display("          got lvl %0d use %0d cnt %0d avg %h mean %h",
							got.level, got.levels_in_use, got.block_count,
							got.block_average, got.running_mean);
						$display("          got m2 %h cov %h sat %b last %b",
							got.sum_sq_dev, got.lag_covariance_sum, got.saturated, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", exp_results.size());
			$display("tb_blocking_analysis_stats_top: errors");
			$finish;
		end
	end

	initial begin
		errors = 0;
		mismatches = 0;
		n_items = 0;
		n_clears = 0;
		n_results = 0;
		idle_cycles = 0;
		max_depth = 0;
		clear_levels();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OPC_SAMPLE;
		req.sample = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_clear();
		test_random(390);
		req.valid = 1'b0;
		while (exp_results.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		if (exp_results.size() != 0) errors++;
		$display("%0d items sent (%0d clears), %0d results checked, deepest level count %0d",
			n_items, n_clears, n_results, max_depth);
		$display("%0d mismatches, %0d errors in total", mismatches, errors);
		if (errors == 0) begin
			$display("tb_blocking_analysis_stats_top: clean");
		end else begin
			$display("tb_blocking_analysis_stats_top: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bas_pkg.sv
sv/bas_in_if.sv
sv/bas_out_if.sv
sv/bas_mul.sv
sv/bas_div.sv
sv/bas_dp.sv
sv/bas_ctrl.sv
sv/blocking_analysis_stats_top.sv
sim/tb_blocking_analysis_stats_top.sv
